// File: rtl/assert_macros.svh
// assertion macros used by the stack top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked outside reset
`define STK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack assertion failed");

// condition that must hold in the cycle after reset
`define STK_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("stack reset assertion failed");

`endif

// File: rtl/stk_pkg.sv
// shared types and constants of the indexed lifo stack
package stk_pkg;

  localparam int DEPTH    = 8;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int FUNC_W   = 3;
  localparam int COUNT_W  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_DISPLAY = 3'd3,
    OP_CHANGE  = 3'd4,
    OP_PEEP    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADPOS   = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             disp_active;
  } back_stat_t;

endpackage

// File: rtl/stk_front.sv
// front end: accepts items, drops unused codes, queues commands
module stk_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [stk_pkg::FUNC_W-1:0] func,
  input  logic [stk_pkg::DATA_W-1:0] value,
  input  logic [stk_pkg::POS_W-1:0]  position,
  input  logic                       push,
  output logic                       full,
  output logic                       cmd_valid,
  output stk_pkg::cmd_t              cmd,
  input  logic                       cmd_take
);
  import stk_pkg::*;

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              op_ok;
  logic              keep;
  logic              take;

  always_comb begin
    case (op_t'(func))
      OP_PUSH, OP_POP, OP_PEEK, OP_DISPLAY, OP_CHANGE, OP_PEEP: op_ok = 1'b1;
      default: op_ok = 1'b0;
    endcase
  end

  assign full      = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign keep      = push && !full && op_ok;
  assign cmd_valid = (cnt != '0);
  assign take      = cmd_take && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (keep) begin
      q[wr_ptr] <= '{op: op_t'(func), value: value, position: position};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (keep) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      case ({keep, take})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: rtl/stk_back.sv
// back end: stack storage and command execution
module stk_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  stk_pkg::cmd_t       cmd,
  output logic                cmd_take,
  input  logic                res_space,
  output logic                res_valid,
  output stk_pkg::result_t    res,
  output stk_pkg::back_stat_t stat
);
  import stk_pkg::*;

  logic [DATA_W-1:0] store [DEPTH];
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  cur;
  logic [CNT_W-1:0]  cur_next;
  logic              disp_active;
  logic              disp_active_next;
  logic [POS_W-1:0]  fill_ext;
  logic              pos_bad;
  logic [POS_W-1:0]  pos_slot;
  logic [CNT_W-1:0]  disp_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;
  logic              go;

  assign go       = cmd_valid && res_space;
  assign fill_ext = POS_W'(fill);
  assign pos_bad  = (cmd.position == '0) || (cmd.position > fill_ext);
  assign pos_slot = fill_ext - cmd.position;
  assign disp_idx = disp_active ? cur : fill;

  always_comb begin
    fill_next        = fill;
    cur_next         = cur;
    disp_active_next = disp_active;
    rd_addr          = ADDR_W'(fill - 1'b1);
    wr_addr          = ADDR_W'(fill);
    wr_en            = 1'b0;
    cmd_take         = 1'b0;
    res_valid        = 1'b0;
    res.status       = ST_OK;
    res.data         = '0;
    res.last         = 1'b1;
    case (cmd.op)
      OP_PUSH: begin
        if (fill == CNT_W'(DEPTH)) begin
          res.status = ST_OVERFLOW;
        end else begin
          wr_en     = go;
          fill_next = go ? fill + 1'b1 : fill;
        end
        res_valid = go;
        cmd_take  = go;
      end
      OP_POP, OP_PEEK: begin
        if (fill == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = store[rd_addr];
          if (go && cmd.op == OP_POP) fill_next = fill - 1'b1;
        end
        res_valid = go;
        cmd_take  = go;
      end
      OP_DISPLAY: begin
        rd_addr   = ADDR_W'(disp_idx - 1'b1);
        res_valid = go;
        if (fill == '0) begin
          res.status = ST_EMPTY;
          cmd_take   = go;
        end else begin
          res.data = store[rd_addr];
          res.last = (disp_idx == CNT_W'(1));
          cmd_take = go && res.last;
          if (go) begin
            disp_active_next = !res.last;
            cur_next         = disp_idx - 1'b1;
          end
        end
      end
      OP_CHANGE: begin
        wr_addr = ADDR_W'(pos_slot);
        if (pos_bad) res.status = ST_BADPOS;
        else         wr_en      = go;
        res_valid = go;
        cmd_take  = go;
      end
      OP_PEEP: begin
        rd_addr = ADDR_W'(pos_slot);
        if (pos_bad) res.status = ST_BADPOS;
        else         res.data   = store[rd_addr];
        res_valid = go;
        cmd_take  = go;
      end
      default: begin
        cmd_take = cmd_valid;
      end
    endcase
    res.count = COUNT_W'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= cmd.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      cur         <= '0;
      disp_active <= 1'b0;
    end else begin
      fill        <= fill_next;
      cur         <= cur_next;
      disp_active <= disp_active_next;
    end
  end

  assign stat.fill        = fill;
  assign stat.disp_active = disp_active;

endmodule

// File: rtl/stk_outq.sv
// two-entry result queue feeding the result ports
module stk_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  stk_pkg::result_t res,
  output logic             res_space,
  output stk_pkg::result_t head,
  output logic             empty,
  input  logic             pop
);
  import stk_pkg::*;

  result_t           q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              wr;
  logic              rd;

  assign res_space = (cnt != QCNT_W'(QUEUE_DEPTH));
  assign empty     = (cnt == '0);
  assign wr        = res_valid && res_space;
  assign rd        = pop && !empty;
  assign head      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) q[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: rtl/lifo_stack_with_indexed_access_top.sv
// top level of the bounded lifo stack with indexed access
//
// input channel: func, value and position, with push and full. a transfer
//   happens at a clock edge with push high and full low. codes 6 and 7 are
//   taken and dropped without a result
// result channel: status, data, count and last, with empty and pop. the
//   oldest result sits on the ports while empty is low; a transfer happens
//   at a clock edge with pop high and empty low
// path: the command queue registers each item and the result queue its result
// throughput: one item per cycle for push, pop, peek, change and peep while
//   the result queue has room; a display of n entries gives n results from
//   the execute stage, one at a time, with last marking the final one. the
//   execute stage and its single read of the eight-entry register file set this rate
// a two-entry command queue sits between intake and execute, and a
//   two-entry result queue between execute and the result ports, so either
//   side may stall on its own. when the receiver stops popping, the result
//   queue fills, then the command queue, then full rises
// reset (rst, synchronous): empties both queues and the stack; store words
//   are not cleared, only entries below the fill level are ever read
module lifo_stack_with_indexed_access_top (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          func,
  input  logic signed [31:0]  value,
  input  logic [7:0]          position,
  input  logic                push,
  output logic                full,
  output logic [1:0]          status,
  output logic signed [31:0]  data,
  output logic [3:0]          count,
  output logic                last,
  output logic                empty,
  input  logic                pop
);
  import stk_pkg::*;

  `include "assert_macros.svh"

  // front to back command path
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_take;

  // back to result queue path
  logic       res_valid;
  result_t    res;
  logic       res_space;
  result_t    head;
  back_stat_t stat;

  stk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .value     (value),
    .position  (position),
    .push      (push),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  stk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_space (res_space),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  stk_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_space (res_space),
    .head      (head),
    .empty     (empty),
    .pop       (pop)
  );

  // result fields straight from the queue head
  assign status = head.status;
  assign data   = head.data;
  assign count  = head.count;
  assign last   = head.last;

  // fill level never goes past the stack depth
  `STK_ASSERT_IMP(a_fill_bound, 1'b1, stat.fill <= CNT_W'(DEPTH))
  // a display walk is only in progress on a non-empty stack
  `STK_ASSERT_IMP(a_disp_nonempty, stat.disp_active, stat.fill != '0)
  // a shown result never reports more entries than the depth
  `STK_ASSERT_IMP(a_count_bound, !empty, count <= COUNT_W'(DEPTH))
  // after reset the result queue is empty, full is low and no display runs
  `STK_ASSERT_RST(a_reset_clear, empty && !full && !stat.disp_active)

endmodule

// File: dv/lifo_stack_with_indexed_access_top_test.sv
// self-checking testbench for the bounded lifo stack with indexed access
`timescale 1ns / 100ps

module lifo_stack_with_indexed_access_top_test;
  import stk_pkg::*;

  // function codes 6 and 7 are spare: the block drops them without a result
  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_PCT     = 16;
  localparam int HOLD_LEN     = 80;
  localparam int SETTLE       = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 100;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [7:0]         position;
  } stack_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [2:0]         func = '0;
  logic signed [31:0] value = '0;
  logic [7:0]         position = '0;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [3:0]         count;
  logic               last;
  logic               empty;
  logic               pop = 1'b0;

  lifo_stack_with_indexed_access_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .func     (func),
    .value    (value),
    .position (position),
    .push     (push),
    .full     (full),
    .status   (status),
    .data     (data),
    .count    (count),
    .last     (last),
    .empty    (empty),
    .pop      (pop)
  );

  // items waiting to be offered, and results owed by the block, oldest first
  stack_cmd_t pending_cmds[$];
  result_t    owed_results[$];

  // shadow copy of the stack contents
  logic signed [31:0] shadow_words[DEPTH];
  int unsigned        shadow_fill = 0;

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;

  // receiver hold-off: the stimulus bumps hold_requests, the hold process
  // loads hold_cycles from HOLD_LEN and holds pop low until it counts down
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_cycles   = 0;

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // stack predictor
  // ---------------------------------------------------------------------

  function automatic void owe_result(status_t st, logic [31:0] word, logic fin);
    result_t r;
    r.status = st;
    r.data   = word;
    r.count  = shadow_fill[3:0];
    r.last   = fin;
    owed_results.push_back(r);
  endfunction

  // applies one accepted item to the shadow stack and queues what it yields
  function automatic void apply_stack_cmd(stack_cmd_t c);
    int unsigned slot;
    logic        pos_ok;
    pos_ok = (c.position != 0) && (c.position <= shadow_fill);
    slot   = shadow_fill - c.position;
    case (c.func)
      OP_PUSH: begin
        if (shadow_fill == DEPTH) begin
          owe_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          shadow_words[shadow_fill] = c.value;
          shadow_fill++;
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          shadow_fill--;
          owe_result(ST_OK, shadow_words[shadow_fill], 1'b1);
        end
      end
      OP_PEEK: begin
        if (shadow_fill == 0) owe_result(ST_EMPTY, '0, 1'b1);
        else owe_result(ST_OK, shadow_words[shadow_fill - 1], 1'b1);
      end
      OP_DISPLAY: begin
        // whole listing, top entry first; an empty stack gives one empty result
        if (shadow_fill == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = shadow_fill; i > 0; i--)
            owe_result(ST_OK, shadow_words[i - 1], i == 1);
        end
      end
      OP_CHANGE: begin
        if (!pos_ok) begin
          owe_result(ST_BADPOS, '0, 1'b1);
        end else begin
          shadow_words[slot] = c.value;
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_PEEP: begin
        if (!pos_ok) owe_result(ST_BADPOS, '0, 1'b1);
        else owe_result(ST_OK, shadow_words[slot], 1'b1);
      end
      default: ;  // spare codes: no result, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // driver: offers pending items, holds an item steady until its transfer
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    stack_cmd_t c;
    logic       taken;
    if (rst) begin
      push <= 1'b0;
    end else begin
      taken = push && !full;
      if (taken) begin
        c.func     = func;
        c.value    = value;
        c.position = position;
        apply_stack_cmd(c);
      end
      // an offered item that was not taken stays on the ports
      if (push && !taken) begin
        push <= 1'b1;
      end else if (pending_cmds.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        c = pending_cmds.pop_front();
        func     <= c.func;
        value    <= c.value;
        position <= c.position;
        push     <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver hold-off, counted in its own process
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_cycles <= HOLD_LEN;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks each result transfer against the oldest owed result
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("unexpected result: status %0d data %h count %0d last %0b",
                     status, data, count, last);
        end else begin
          want = owed_results.pop_front();
          if (status !== want.status || data !== want.data ||
              count !== want.count || last !== want.last) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
              $display("mismatch: expected status %0d data %h count %0d last %0b",
                       want.status, want.data, want.count, want.last);
              $display("          got      status %0d data %h count %0d last %0b",
                       status, data, count, last);
            end
          end
        end
      end
      pop <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lifo_stack_with_indexed_access_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  function automatic void add_cmd(logic [2:0] f, logic signed [31:0] v, logic [7:0] p);
    stack_cmd_t c;
    c.func     = f;
    c.value    = v;
    c.position = p;
    pending_cmds.push_back(c);
  endfunction

  // random item, mostly well-formed: positions near the fill level, codes
  // weighted toward push so the stack spends time both deep and shallow
  function automatic stack_cmd_t random_cmd(int push_pct);
    stack_cmd_t c;
    int         r;
    r = $urandom_range(99);
    if (r < push_pct)                 c.func = OP_PUSH;
    else if (r < push_pct + 18)       c.func = OP_POP;
    else if (r < push_pct + 26)       c.func = OP_PEEK;
    else if (r < push_pct + 33)       c.func = OP_DISPLAY;
    else if (r < push_pct + 45)       c.func = OP_CHANGE;
    else if (r < 97)                  c.func = OP_PEEP;
    else if (r == 97)                 c.func = FUNC_SPARE_A;
    else                              c.func = FUNC_SPARE_B;
    case ($urandom_range(9))
      0:       c.value = 32'sh7fff_ffff;
      1:       c.value = 32'sh8000_0000;
      default: c.value = $urandom;
    endcase
    if ($urandom_range(9) < 8) c.position = 8'($urandom_range(0, DEPTH + 1));
    else c.position = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // queues n random items that the block acts on; spare codes ride along free
  task automatic queue_random(int n, int push_pct);
    stack_cmd_t c;
    int         made;
    made = 0;
    while (made < n) begin
      c = random_cmd(push_pct);
      pending_cmds.push_back(c);
      if (c.func <= OP_PEEP) made++;
    end
  endtask

  // sender pause: nothing more is offered until every owed result came back
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || push || owed_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every operation but push on an empty stack, spare codes
    add_cmd(OP_POP,       '0, 8'd0);
    add_cmd(OP_PEEK,      '0, 8'd0);
    add_cmd(OP_DISPLAY,   '0, 8'd0);
    add_cmd(OP_CHANGE,    32'sd5, 8'd1);
    add_cmd(OP_PEEP,      '0, 8'd0);
    add_cmd(FUNC_SPARE_A, '0, 8'd1);
    add_cmd(FUNC_SPARE_B, '1, 8'd255);
    // fill to the top with extreme words, then overflow
    add_cmd(OP_PUSH, 32'sh7fff_ffff, 8'd0);
    add_cmd(OP_PUSH, 32'sh8000_0000, 8'd0);
    add_cmd(OP_PUSH, 32'sh0000_0000, 8'd0);
    add_cmd(OP_PUSH, -32'sd1,        8'd0);
    add_cmd(OP_PUSH, 32'shaaaa_aaaa, 8'd0);
    add_cmd(OP_PUSH, 32'sh5555_5555, 8'd0);
    add_cmd(OP_PUSH, 32'sd1,         8'd0);
    add_cmd(OP_PUSH, 32'sd2,         8'd0);
    add_cmd(OP_PUSH, 32'sd3,         8'd0);
    // full listing, position edges, writes at top and bottom
    add_cmd(OP_DISPLAY, '0, 8'd0);
    add_cmd(OP_PEEP,    '0, 8'd1);
    add_cmd(OP_PEEP,    '0, 8'd8);
    add_cmd(OP_PEEP,    '0, 8'd255);
    add_cmd(OP_CHANGE,  32'sh1234_5678, 8'd0);
    add_cmd(OP_CHANGE,  32'sh8765_4321, 8'd8);
    add_cmd(OP_CHANGE,  32'sh0bad_cafe, 8'd1);
    add_cmd(OP_PEEK,    '0, 8'd0);
    add_cmd(OP_POP,     '0, 8'd0);
    wait_drained();

    // random traffic under normal idling on both sides
    queue_random(40, 30);
    wait_drained();

    // receiver stalls a long while; the sender keeps offering until the
    // result queue and command queue fill and full rises
    hold_requests++;
    queue_random(30, 45);
    wait_drained();

    // stretch with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_ITEMS - 70, 30);
    wait_drained();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;

    repeat (SETTLE) @(negedge clk);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("lifo_stack_with_indexed_access_top test passed");
    end else begin
      $display("lifo_stack_with_indexed_access_top test failed");
    end
    $finish;
  end

endmodule
